[hw/rtl/rslm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rslm_pkg
// Types and constants shared by the RTP sequence loss monitor.
// ---------------------------------------------------------------------------
package rslm_pkg;

  localparam int SEQ_W       = 16;
  localparam int CNT_W       = 32;
  localparam int PREV_W      = SEQ_W + 1;
  localparam int NCH         = 2;
  localparam int PROD_W      = CNT_W + 7;
  localparam int PCT_DIV     = 100;
  localparam logic [1:0] WARN_LIMIT = 2'd2;

  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = 2;
  localparam int OUT_CNT_W   = 3;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int ALARM_BIT   = 2 * CNT_W;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int CFG_IDX_W   = 2;

  // request codes
  localparam logic [1:0] REQ_PKT  = 2'd0;
  localparam logic [1:0] REQ_EVAL = 2'd1;
  localparam logic [1:0] REQ_CLR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MCAST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVDIS = 2'd3;

  typedef enum logic [2:0] {
    OP_PKT  = 3'b001,
    OP_EVAL = 3'b010,
    OP_CLR  = 3'b100
  } op_kind_t;

  typedef struct packed {
    logic [PREV_W-1:0] prev;   // bit 16: no number seen yet
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  lost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam entry_t RESET_ENTRY = '{prev: 17'h10000, total: '0, lost: '0};

  typedef struct packed {
    logic             vld;
    op_kind_t         kind;
    logic             ch;
    logic [SEQ_W-1:0] seq;
  } op_t;

  typedef struct packed {
    logic             vld;
    logic             clr;
    logic             nz;     // channel total nonzero
    logic             st;     // first nonzero channel of the evaluation
    logic             last;   // would be the last report
    logic             ch;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lost;
  } rec_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lost;
    logic             alarm;
    logic             last;
  } res_t;

  typedef struct packed {
    logic                 room;
    logic [OUT_CNT_W-1:0] count;
  } rep_sts_t;

endpackage
`default_nettype wire

[hw/rtl/rslm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rslm_ram
// Simple dual-port RAM, one write and one registered read (read-first).
// ---------------------------------------------------------------------------
module rslm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[rd_addr];
  end

  assign rd_data = rdata_r;

endmodule
`default_nettype wire

[hw/rtl/rslm_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rslm_update
// Channel state memory with read-modify-write stage and write forwarding.
// ---------------------------------------------------------------------------
module rslm_update
  import rslm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire op_t  iss_op,
  output rec_t      rec
);

  op_t              ex_op_r;
  logic             rd_vld_r;
  logic [NCH-1:0]   vld_r, vld_nxt;
  logic [NCH-1:0]   nz_r, nz_nxt;
  logic             ev_nz0_r, ev_nz0_nxt;
  logic             fwd_vld_r;
  logic             fwd_ch_r;
  entry_t           fwd_ent_r;
  rec_t             rec_r, rec_nxt;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           cur, ent_nxt;
  logic             fwd_hit;
  logic             le;
  logic             nz_cur;
  logic [PREV_W-1:0] dgap, gap, gap_m1;
  logic [CNT_W:0]   tsum, lsum;

  rslm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NCH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ex_op_r.vld),
    .wr_addr (ex_op_r.ch),
    .wr_data (ent_nxt),
    .rd_addr (iss_op.ch),
    .rd_data (ram_rdata)
  );

  always_comb begin
    fwd_hit = fwd_vld_r && (fwd_ch_r == ex_op_r.ch);
    if (fwd_hit) begin
      cur = fwd_ent_r;
    end else if (rd_vld_r) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = RESET_ENTRY;
    end

    nz_cur = (cur.total != '0);
    le     = (ex_op_r.seq <= cur.prev[SEQ_W-1:0]);
    dgap   = {le, ex_op_r.seq} - {1'b0, cur.prev[SEQ_W-1:0]};
    gap    = cur.prev[SEQ_W] ? PREV_W'(1) : dgap;
    gap_m1 = gap - PREV_W'(1);
    tsum   = {1'b0, cur.total} + (CNT_W+1)'(gap);
    lsum   = {1'b0, cur.lost} + (CNT_W+1)'(gap_m1);

    ent_nxt    = cur;
    vld_nxt    = vld_r;
    nz_nxt     = nz_r;
    ev_nz0_nxt = ev_nz0_r;
    rec_nxt    = '0;
    rec_nxt.ch    = ex_op_r.ch;
    rec_nxt.total = cur.total;
    rec_nxt.lost  = cur.lost;

    if (ex_op_r.vld) begin
      vld_nxt[ex_op_r.ch] = 1'b1;
      case (ex_op_r.kind)
        OP_PKT: begin
          ent_nxt.prev  = {1'b0, ex_op_r.seq};
          ent_nxt.total = tsum[CNT_W] ? '1 : tsum[CNT_W-1:0];
          ent_nxt.lost  = lsum[CNT_W] ? '1 : lsum[CNT_W-1:0];
          nz_nxt[ex_op_r.ch] = 1'b1;
        end
        OP_EVAL: begin
          ent_nxt.total = '0;
          ent_nxt.lost  = '0;
          nz_nxt[ex_op_r.ch] = 1'b0;
          rec_nxt.vld = 1'b1;
          rec_nxt.nz  = nz_cur;
          if (ex_op_r.ch == 1'b0) begin
            rec_nxt.st  = nz_cur;
            rec_nxt.last = !nz_r[1];
            ev_nz0_nxt  = nz_cur;
          end else begin
            rec_nxt.st  = nz_cur && !ev_nz0_r;
            rec_nxt.last = 1'b1;
          end
        end
        OP_CLR: begin
          ent_nxt = RESET_ENTRY;
          nz_nxt[ex_op_r.ch] = 1'b0;
          rec_nxt.vld = 1'b1;
          rec_nxt.clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_op_r   <= '0;
      rd_vld_r  <= 1'b0;
      vld_r     <= '0;
      nz_r      <= '0;
      ev_nz0_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      rec_r     <= '0;
    end else begin
      ex_op_r   <= iss_op;
      rd_vld_r  <= vld_r[iss_op.ch];
      vld_r     <= vld_nxt;
      nz_r      <= nz_nxt;
      ev_nz0_r  <= ev_nz0_nxt;
      fwd_vld_r <= ex_op_r.vld;
      rec_r     <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_ch_r  <= ex_op_r.ch;
    fwd_ent_r <= ent_nxt;
  end

  assign rec = rec_r;

endmodule
`default_nettype wire

[hw/rtl/rslm_report.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rslm_report
// Loss threshold check, alarm counter and report output queue.
// ---------------------------------------------------------------------------
module rslm_report
  import rslm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rec_t                   rec,
  input  wire logic                   show,
  input  wire logic                   mcast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // total, lost, loss_alarm, zero pad
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // report_kind
  output logic                        out_tlast,
  output rep_sts_t                    sts
);

  res_t                 fifo_r [OUT_DEPTH];
  logic [OUT_AW-1:0]    wptr_r, rptr_r;
  logic [OUT_CNT_W-1:0] count_r, count_nxt;
  logic [1:0]           warn_r, warn_nxt;
  logic                 alarm_pend_r, alarm_pend_nxt;
  logic [PROD_W-1:0]    prod;
  logic                 over;
  logic [1:0]           w1, wn;
  logic                 hit, alarm_now;
  logic                 push, pop;
  res_t                 res, head;

  always_comb begin
    // lost > total / 100  <=>  100 * lost > total
    prod      = PROD_W'(rec.lost) * PROD_W'(PCT_DIV);
    over      = prod > PROD_W'(rec.total);
    w1        = warn_r + 2'd1;
    wn        = over ? w1 : 2'd0;
    hit       = (wn >= WARN_LIMIT);
    alarm_now = hit && show;

    warn_nxt       = warn_r;
    alarm_pend_nxt = alarm_pend_r;
    if (rec.vld && rec.clr) begin
      warn_nxt = 2'd0;
    end else if (rec.vld && rec.st) begin
      warn_nxt       = hit ? 2'd0 : wn;
      alarm_pend_nxt = alarm_now;
    end

    push = rec.vld && !rec.clr && rec.nz && show;
    res.kind  = {rec.ch, mcast};
    res.total = rec.total;
    res.lost  = rec.lost;
    res.last  = rec.last;
    res.alarm = rec.last && (rec.st ? alarm_now : alarm_pend_r);

    head = fifo_r[rptr_r];
    pop  = out_tvalid && out_tready;
    count_nxt = count_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r       <= '0;
      rptr_r       <= '0;
      count_r      <= '0;
      warn_r       <= 2'd0;
      alarm_pend_r <= 1'b0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + OUT_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + OUT_AW'(1);
      end
      count_r      <= count_nxt;
      warn_r       <= warn_nxt;
      alarm_pend_r <= alarm_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= res;
    end
  end

  // three transfers can be in flight behind the issue point
  assign sts.room  = (count_r <= OUT_CNT_W'(OUT_DEPTH - 3));
  assign sts.count = count_r;

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {(OUT_TDATA_W-ALARM_BIT-1)'(0), head.alarm, head.lost, head.total};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule
`default_nettype wire

[hw/rtl/rtp_sequence_loss_monitor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtp_sequence_loss_monitor
// RTP packet loss counter for a raw and a corrected channel.
// Input stream: one transfer per request; tuser holds the request type and
// channel, tdata the 16-bit sequence number. Packet transfers update the
// channel's total and lost counts and give no output. Evaluation transfers
// produce up to two reports (raw, then corrected) on the output stream,
// tlast on the final one, then clear the counts; a reset transfer clears all.
// Packets are taken one per cycle while the output buffer has room.
// Evaluation and reset transfers issue one pass per channel entry, raw then
// corrected, through the single read port of the state RAM; reads of an
// entry written the cycle before are forwarded. Reports pass through the
// record register into a four-entry output buffer; input is held off when
// the receiver stalls and the buffer holds more than one report.
// After rst_n the counts read as cleared (per-entry valid flags), no clearing
// pass is needed, and all configuration registers are zero. The configuration
// port is always ready and must be written only while idle; no logic enforces it.
// ---------------------------------------------------------------------------
module rtp_sequence_loss_monitor
  import rslm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic                   cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // seq
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // req_type, channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // report_total, report_lost, loss_alarm
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // report_kind
  output logic                        out_tlast
);

  logic     play_r, pip_r, mcast_r, evdis_r;
  logic     hold_r, hold_nxt;
  op_kind_t hold_kind_r, hold_kind_nxt;
  op_t      iss_op;
  rec_t     rec;
  rep_sts_t rep_sts;
  logic     in_fire;
  logic     show;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r  <= 1'b0;
      pip_r   <= 1'b0;
      mcast_r <= 1'b0;
      evdis_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAY:  play_r  <= cfg_data;
        CFG_PIP:   pip_r   <= cfg_data;
        CFG_MCAST: mcast_r <= cfg_data;
        CFG_EVDIS: evdis_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign show      = play_r && !pip_r;
  assign in_tready = !hold_r && rep_sts.room;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    iss_op        = '0;
    iss_op.kind   = OP_PKT;
    iss_op.seq    = in_tdata[SEQ_W-1:0];
    hold_nxt      = hold_r;
    hold_kind_nxt = hold_kind_r;
    if (hold_r) begin
      if (rep_sts.room) begin
        iss_op.vld  = 1'b1;
        iss_op.kind = hold_kind_r;
        iss_op.ch   = 1'b1;
        hold_nxt    = 1'b0;
      end
    end else if (in_fire) begin
      case (in_tuser[1:0])
        REQ_PKT: begin
          iss_op.vld = 1'b1;
          iss_op.ch  = in_tuser[2];
        end
        REQ_EVAL: begin
          if (!evdis_r) begin
            iss_op.vld    = 1'b1;
            iss_op.kind   = OP_EVAL;
            hold_nxt      = 1'b1;
            hold_kind_nxt = OP_EVAL;
          end
        end
        REQ_CLR: begin
          if (play_r) begin
            iss_op.vld    = 1'b1;
            iss_op.kind   = OP_CLR;
            hold_nxt      = 1'b1;
            hold_kind_nxt = OP_CLR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      hold_kind_r <= OP_EVAL;
    end else begin
      hold_r      <= hold_nxt;
      hold_kind_r <= hold_kind_nxt;
    end
  end

  rslm_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .iss_op (iss_op),
    .rec    (rec)
  );

  rslm_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (rec),
    .show       (show),
    .mcast      (mcast_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .sts        (rep_sts)
  );

  a_eval_second_half: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] == REQ_EVAL && !evdis_r) |=> hold_r)
    else $error("evaluation did not schedule its corrected-channel pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rep_sts.count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("report queue overflow");

  a_alarm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ALARM_BIT]) |-> out_tlast)
    else $error("loss alarm on a report that is not the last");

endmodule
`default_nettype wire
